[src/edge_period_capacitance_meter_unit_assert.svh]
// ---------------------------------------------------------------------------
// edge period capacitance meter assertion macros
// concurrent assertion shorthands clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef EDGE_PERIOD_CAPACITANCE_METER_UNIT_ASSERT_SVH
`define EDGE_PERIOD_CAPACITANCE_METER_UNIT_ASSERT_SVH

// same-cycle implication
`define EPCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EPCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/epcm_pkg.sv]
// ---------------------------------------------------------------------------
// epcm_pkg
// shared constants, configuration struct and register indexes
// ---------------------------------------------------------------------------
package epcm_pkg;

  localparam int WINDOW = 100;
  localparam int SLOT_W = $clog2(WINDOW);

  localparam int TS_W   = 32;
  localparam int FREQ_W = 40;
  localparam int FCAL_W = 42;
  localparam int CAP_W  = 36;
  localparam int SUM_W  = 47;

  // shared restoring divider
  localparam int DVD_W  = 48;
  localparam int DVS_W  = 42;
  localparam int DCNT_W = $clog2(DVD_W + 1);

  // window mean by reciprocal multiplication, one 16-bit chunk per step
  localparam int MDIV_CHUNK   = 16;
  localparam int MDIV_STEPS   = 3;
  localparam int MDIV_STEP_W  = 2;
  localparam int MDIV_NUM_W   = MDIV_CHUNK * MDIV_STEPS;
  localparam int MDIV_REM_W   = 7;
  localparam int MDIV_V_W     = MDIV_REM_W + MDIV_CHUNK;
  localparam int MDIV_SHIFT   = 30;
  localparam int MDIV_RECIP_W = MDIV_SHIFT;
  localparam int MDIV_PROD_W  = MDIV_V_W + MDIV_RECIP_W;
  localparam logic [MDIV_RECIP_W-1:0] MDIV_RECIP =
    MDIV_RECIP_W'(((64'd1 << MDIV_SHIFT) + WINDOW - 1) / WINDOW);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CORE_CLOCK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_NUM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_OFFSET  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_GAIN    = 3'd5;

  typedef struct packed {
    logic [31:0] core_clock_hz;
    logic [16:0] freq_gain_q16;
    logic [15:0] freq_offset_q8;
    logic [31:0] cap_numerator;
    logic [16:0] cap_offset_q4;
    logic [16:0] cap_gain_q16;
  } cfg_t;

  localparam logic [31:0] RST_CORE_CLOCK  = 32'd72000000;
  localparam logic [16:0] RST_FREQ_GAIN   = 17'd65851;
  localparam logic [15:0] RST_FREQ_OFFSET = 16'hFFF3;   // -13
  localparam logic [31:0] RST_CAP_NUM     = 32'd717759;
  localparam logic [16:0] RST_CAP_OFFSET  = 17'h1FDB6;  // -586
  localparam logic [16:0] RST_CAP_GAIN    = 17'd65736;

endpackage

[src/epcm_ram.sv]
// ---------------------------------------------------------------------------
// epcm_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
module epcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/epcm_front.sv]
// ---------------------------------------------------------------------------
// epcm_front
// accepts edge timestamps, arms on the first, pushes tick differences
// ---------------------------------------------------------------------------
module epcm_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [epcm_pkg::TS_W-1:0] edge_timestamp,
  input  logic                      q_full,
  output logic                      q_push,
  output logic [epcm_pkg::TS_W-1:0] q_data
);
  import epcm_pkg::*;

  logic            armed;
  logic [TS_W-1:0] prev_timestamp;
  logic [TS_W-1:0] diff;
  logic            accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign diff     = edge_timestamp - prev_timestamp;
  // zero period counts as one tick
  assign q_data   = (diff == '0) ? TS_W'(1) : diff;
  assign q_push   = accept && armed;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed          <= 1'b0;
      prev_timestamp <= '0;
    end else if (accept) begin
      armed          <= 1'b1;
      prev_timestamp <= edge_timestamp;
    end
  end
endmodule

[src/epcm_fifo.sv]
// ---------------------------------------------------------------------------
// epcm_fifo
// short queue of tick differences between front and back
// ---------------------------------------------------------------------------
module epcm_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [epcm_pkg::TS_W-1:0] wdata,
  input  logic                      pop,
  output logic [epcm_pkg::TS_W-1:0] rdata,
  output logic                      full,
  output logic                      empty
);
  import epcm_pkg::*;

  logic [TS_W-1:0]    mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_CW-1:0] count;

  assign full  = (count == FIFO_CW'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

[src/epcm_div.sv]
// ---------------------------------------------------------------------------
// epcm_div
// restoring unsigned divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module epcm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [epcm_pkg::DVD_W-1:0] dividend,
  input  logic [epcm_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [epcm_pkg::DVD_W-1:0] quotient
);
  import epcm_pkg::*;

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [DVS_W:0]    rem;
  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W:0]    rem_sh;
  logic              ge;
  logic [DVS_W:0]    rem_next;

  assign rem_sh   = {rem[DVS_W-1:0], dvd[DVD_W-1]};
  assign ge       = (rem_sh >= {1'b0, dvs});
  assign rem_next = ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DVD_W);
        rem  <= '0;
        dvd  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[DVD_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[src/epcm_back.sv]
// ---------------------------------------------------------------------------
// epcm_back
// frequency, window mean and capacitance sequencer with output register
// ---------------------------------------------------------------------------
`include "edge_period_capacitance_meter_unit_assert.svh"

module epcm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  epcm_pkg::cfg_t              cfg,
  input  logic                        q_empty,
  input  logic [epcm_pkg::TS_W-1:0]   q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [epcm_pkg::FREQ_W-1:0] freq_now_q8,
  output logic [epcm_pkg::FCAL_W-1:0] freq_mean_cal_q8,
  output logic [epcm_pkg::CAP_W-1:0]  capacitance_q4,
  output logic                        cap_clamped
);
  import epcm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FDIV, S_WIN, S_MDIV, S_FMUL, S_FCAL, S_CDIV, S_CMUL, S_CSAT, S_OUT
  } state_t;

  state_t            state;
  logic [SLOT_W-1:0] write_slot;
  logic [WINDOW-1:0] slot_vld;
  logic [SUM_W-1:0]  window_sum;
  logic [FREQ_W-1:0] fnow;
  logic [FREQ_W-1:0] mean;
  logic [56:0]       prod_f;
  logic [FCAL_W-1:0] fcal;
  logic [44:0]       c_val;
  logic [61:0]       prod_c;
  logic [CAP_W-1:0]  cap;
  logic              clamp;

  logic                   div_start;
  logic [DVD_W-1:0]       div_dvd;
  logic [DVS_W-1:0]       div_dvs;
  logic                   div_done;
  logic [DVD_W-1:0]       div_q;
  logic [FREQ_W-1:0]      ram_rdata;
  logic [FREQ_W-1:0]      old_f;
  logic [SUM_W-1:0]       sum_next;
  logic [FCAL_W-1:0]      fcal_next;
  logic [45:0]            c_next;
  logic                   out_free;
  logic                   out_load;

  logic [MDIV_NUM_W-1:0]  mdiv_num;
  logic [MDIV_REM_W-1:0]  mdiv_rem;
  logic [MDIV_STEP_W-1:0] mdiv_step;
  logic [MDIV_V_W-1:0]    mdiv_v;
  logic [MDIV_PROD_W-1:0] mdiv_prod;
  logic [MDIV_CHUNK-1:0]  mdiv_q;
  logic [MDIV_V_W-1:0]    mdiv_back;
  logic [MDIV_REM_W-1:0]  mdiv_rem_next;
  logic [MDIV_NUM_W-1:0]  mdiv_num_next;

  epcm_ram #(.WIDTH(FREQ_W), .DEPTH(WINDOW)) u_ram (
    .clk   (clk),
    .we    (state == S_WIN),
    .waddr (write_slot),
    .wdata (fnow),
    .raddr (write_slot),
    .rdata (ram_rdata)
  );

  epcm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // never written slots read as zero
  assign old_f     = slot_vld[write_slot] ? ram_rdata : '0;
  assign sum_next  = window_sum - SUM_W'(old_f) + SUM_W'(fnow);
  assign fcal_next = {1'b0, prod_f[56:16]} + {{(FCAL_W-16){cfg.freq_offset_q8[15]}},
                                              cfg.freq_offset_q8};
  assign c_next    = {2'b0, div_q[43:0]} + {{29{cfg.cap_offset_q4[16]}}, cfg.cap_offset_q4};
  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = (state == S_OUT) && out_free;

  // sum over window: long division by chunks, quotient digit by reciprocal
  assign mdiv_v        = {mdiv_rem, mdiv_num[MDIV_NUM_W-1 -: MDIV_CHUNK]};
  assign mdiv_prod     = mdiv_v * MDIV_RECIP;
  assign mdiv_q        = mdiv_prod[MDIV_SHIFT +: MDIV_CHUNK];
  assign mdiv_back     = MDIV_V_W'(mdiv_q) * MDIV_V_W'(WINDOW);
  assign mdiv_rem_next = MDIV_REM_W'(mdiv_v - mdiv_back);
  assign mdiv_num_next = {mdiv_num[MDIV_NUM_W-MDIV_CHUNK-1:0], mdiv_q};

  always_comb begin
    div_start = 1'b0;
    div_dvd   = {8'b0, cfg.core_clock_hz, 8'b0};
    div_dvs   = DVS_W'(q_data);
    case (state)
      S_IDLE: begin
        div_start = !q_empty;
      end
      S_FCAL: begin
        div_start = !(fcal_next[FCAL_W-1] || (fcal_next == '0));
        div_dvd   = {4'b0, cfg.cap_numerator, 12'b0};
        div_dvs   = fcal_next;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      write_slot <= SLOT_W'(1 % WINDOW);
      slot_vld   <= '0;
      window_sum <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (div_done) begin
            fnow  <= div_q[FREQ_W-1:0];
            state <= S_WIN;
          end
        end
        S_WIN: begin
          window_sum           <= sum_next;
          slot_vld[write_slot] <= 1'b1;
          write_slot <= (write_slot == SLOT_W'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
          mdiv_num   <= MDIV_NUM_W'(sum_next);
          mdiv_rem   <= '0;
          mdiv_step  <= '0;
          state      <= S_MDIV;
        end
        S_MDIV: begin
          mdiv_num  <= mdiv_num_next;
          mdiv_rem  <= mdiv_rem_next;
          mdiv_step <= mdiv_step + 1'b1;
          if (mdiv_step == MDIV_STEP_W'(MDIV_STEPS - 1)) begin
            mean  <= mdiv_num_next[FREQ_W-1:0];
            state <= S_FMUL;
          end
        end
        S_FMUL: begin
          prod_f <= mean * cfg.freq_gain_q16;
          state  <= S_FCAL;
        end
        S_FCAL: begin
          fcal <= fcal_next;
          if (fcal_next[FCAL_W-1] || (fcal_next == '0)) begin
            clamp <= 1'b1;
            cap   <= '0;
            state <= S_OUT;
          end else begin
            state <= S_CDIV;
          end
        end
        S_CDIV: begin
          if (div_done) begin
            if (c_next[45]) begin
              clamp <= 1'b1;
              cap   <= '0;
              state <= S_OUT;
            end else begin
              clamp <= 1'b0;
              c_val <= c_next[44:0];
              state <= S_CMUL;
            end
          end
        end
        S_CMUL: begin
          prod_c <= c_val * cfg.cap_gain_q16;
          state  <= S_CSAT;
        end
        S_CSAT: begin
          // saturate at the top of the field
          cap   <= (prod_c[61:16] > {10'b0, {CAP_W{1'b1}}}) ? {CAP_W{1'b1}}
                                                           : prod_c[16+CAP_W-1:16];
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            freq_now_q8      <= fnow;
            freq_mean_cal_q8 <= fcal;
            capacitance_q4   <= cap;
            cap_clamped      <= clamp;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `EPCM_ASSERT_NOW(a_div_done_wait, div_done,
    (state == S_FDIV) || (state == S_MDIV) || (state == S_CDIV),
    "divider finished outside a wait state")
  `EPCM_ASSERT_NOW(a_slot_range, 1'b1, write_slot < SLOT_W'(WINDOW),
    "window slot out of range")
  `EPCM_ASSERT_NOW(a_clamp_zero, out_valid && cap_clamped, capacitance_q4 == '0,
    "clamped result carries nonzero capacitance")
endmodule

[src/edge_period_capacitance_meter_unit.sv]
// ---------------------------------------------------------------------------
// edge_period_capacitance_meter_unit
// reciprocal frequency counter with moving average and capacitance readout
// ---------------------------------------------------------------------------
// Each accepted timestamp is a tick count captured at an oscillator edge. The
// first edge after reset only arms the meter; every later edge yields one
// result transfer holding the instantaneous frequency (Q8 Hz), the calibrated
// mean over the last 100 periods (signed Q8 Hz) and the calibrated capacitance
// (Q4 pF, clamped at zero with cap_clamped set). A front stage takes the
// timestamp, forms the wrapped tick difference and queues it (two entries);
// the back stage works it out with one shared restoring divider, and takes
// the window mean by a three-step reciprocal multiply. An edge takes the
// back stage through two divisions plus window update, mean, multiplies and
// output; the capacitance multiply is skipped when the capacitance goes
// negative, and the second division too when the mean is not positive. The
// divider sets the sustained rate, and a stalled result adds its wait on top.
// The window ring sits in a ram with per-slot valid bits, so no clearing
// pass is needed after reset. The user must write configuration registers
// only while the meter is idle; the block itself does not enforce this.
module edge_period_capacitance_meter_unit (
  input  logic                            clk,
  input  logic                            rst,
  // timestamp channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [epcm_pkg::TS_W-1:0]       edge_timestamp,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [epcm_pkg::FREQ_W-1:0]     freq_now_q8,
  output logic [epcm_pkg::FCAL_W-1:0]     freq_mean_cal_q8,
  output logic [epcm_pkg::CAP_W-1:0]      capacitance_q4,
  output logic                            cap_clamped,
  // configuration writes
  input  logic                            cfg_write_en,
  input  logic [epcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [epcm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import epcm_pkg::*;

  cfg_t            cfg;
  logic            q_push;
  logic [TS_W-1:0] q_wdata;
  logic            q_pop;
  logic [TS_W-1:0] q_rdata;
  logic            q_full;
  logic            q_empty;

  // configuration register file, upper data bits dropped per register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.core_clock_hz  <= RST_CORE_CLOCK;
      cfg.freq_gain_q16  <= RST_FREQ_GAIN;
      cfg.freq_offset_q8 <= RST_FREQ_OFFSET;
      cfg.cap_numerator  <= RST_CAP_NUM;
      cfg.cap_offset_q4  <= RST_CAP_OFFSET;
      cfg.cap_gain_q16   <= RST_CAP_GAIN;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_CORE_CLOCK:  cfg.core_clock_hz  <= cfg_data;
        REG_FREQ_GAIN:   cfg.freq_gain_q16  <= cfg_data[16:0];
        REG_FREQ_OFFSET: cfg.freq_offset_q8 <= cfg_data[15:0];
        REG_CAP_NUM:     cfg.cap_numerator  <= cfg_data;
        REG_CAP_OFFSET:  cfg.cap_offset_q4  <= cfg_data[16:0];
        REG_CAP_GAIN:    cfg.cap_gain_q16   <= cfg_data[16:0];
        default: begin
          // unknown index, ignored
        end
      endcase
    end
  end

  // front: arming and tick difference
  epcm_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .edge_timestamp (edge_timestamp),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  // queue decoupling the two sides
  epcm_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: divisions, window, calibration and result register
  epcm_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .q_empty          (q_empty),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .freq_now_q8      (freq_now_q8),
    .freq_mean_cal_q8 (freq_mean_cal_q8),
    .capacitance_q4   (capacitance_q4),
    .cap_clamped      (cap_clamped)
  );
endmodule

[verif/testbench.sv]
// ---------------------------------------------------------------------------
// edge period capacitance meter testbench
// drives edge timestamps through the valid/ready channel under several
// calibration settings and checks every result transfer against an
// in-bench model of the frequency window and the capacitance readout
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import epcm_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int SETTLE_CYCLES = 400;   // quiet time before register writes
  localparam int NUM_PHASES = 16;
  localparam int ITEMS_PER_PHASE = 112;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [63:0] CAP_MAX = 64'hF_FFFF_FFFF;

  typedef struct packed {
    logic [FREQ_W-1:0] freq_now;
    logic [FCAL_W-1:0] freq_mean_cal;
    logic [CAP_W-1:0]  cap;
    logic              clamped;
  } meter_result_t;

  // directed edges, expected instantaneous frequency typed where obvious
  typedef struct {
    logic [TS_W-1:0]   ts;
    bit                fnow_known;
    logic [FREQ_W-1:0] fnow;
  } edge_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [TS_W-1:0]       edge_timestamp = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [FREQ_W-1:0]     freq_now_q8;
  logic [FCAL_W-1:0]     freq_mean_cal_q8;
  logic [CAP_W-1:0]      capacitance_q4;
  logic                  cap_clamped;
  logic                  cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  edge_period_capacitance_meter_unit u_dut (.*);

  // clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  cfg_t              cal;
  bit                armed;
  logic [TS_W-1:0]   last_ts;
  logic [FREQ_W-1:0] freq_ring [WINDOW];
  int                ring_slot;
  logic [SUM_W-1:0]  ring_sum;

  meter_result_t pending_results[$];
  int            fail_count = 0;
  int            cycle_count = 0;
  bit            no_idle = 1'b0;
  logic [TS_W-1:0] ts_now = '0;

  function automatic void model_reset();
    cal = '{RST_CORE_CLOCK, RST_FREQ_GAIN, RST_FREQ_OFFSET,
            RST_CAP_NUM, RST_CAP_OFFSET, RST_CAP_GAIN};
    armed = 1'b0;
    last_ts = '0;
    foreach (freq_ring[i]) freq_ring[i] = '0;
    ring_slot = 1;
    ring_sum = '0;
  endfunction

  function automatic void model_config(logic [CFG_IDX_W-1:0] idx,
                                       logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_CORE_CLOCK:  cal.core_clock_hz  = val;
      REG_FREQ_GAIN:   cal.freq_gain_q16  = val[16:0];
      REG_FREQ_OFFSET: cal.freq_offset_q8 = val[15:0];
      REG_CAP_NUM:     cal.cap_numerator  = val;
      REG_CAP_OFFSET:  cal.cap_offset_q4  = val[16:0];
      REG_CAP_GAIN:    cal.cap_gain_q16   = val[16:0];
      default: ;
    endcase
  endfunction

  // one edge: returns 1 and fills r when the edge yields a result
  function automatic bit meter_edge(logic [TS_W-1:0] ts, output meter_result_t r);
    logic [TS_W-1:0] period;
    logic [63:0]     fnow, mean, scaled;
    longint          fcal, c;
    r = '0;
    if (!armed) begin
      armed = 1'b1;
      last_ts = ts;
      return 1'b0;
    end
    period = ts - last_ts;   // wraps modulo 2^32
    if (period == 0) period = 1;
    last_ts = ts;
    fnow = ({24'd0, cal.core_clock_hz, 8'd0} / {32'd0, period}) & 64'hFF_FFFF_FFFF;
    ring_sum = ring_sum - freq_ring[ring_slot] + fnow[FREQ_W-1:0];
    freq_ring[ring_slot] = fnow[FREQ_W-1:0];
    ring_slot = (ring_slot + 1) % WINDOW;
    mean = {17'd0, ring_sum} / WINDOW;
    scaled = (mean * {47'd0, cal.freq_gain_q16}) >> 16;
    fcal = longint'(scaled) + longint'($signed(cal.freq_offset_q8));
    r.freq_now = fnow[FREQ_W-1:0];
    r.freq_mean_cal = fcal[FCAL_W-1:0];
    if (fcal <= 0) begin
      r.clamped = 1'b1;
    end else begin
      c = longint'(({20'd0, cal.cap_numerator, 12'd0}) / 64'(fcal))
          + longint'($signed(cal.cap_offset_q4));
      if (c < 0) begin
        r.clamped = 1'b1;
      end else begin
        scaled = (64'(c) * {47'd0, cal.cap_gain_q16}) >> 16;
        if (scaled > CAP_MAX) scaled = CAP_MAX;
        r.cap = scaled[CAP_W-1:0];
      end
    end
    return 1'b1;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result transfers, compared field by field with the oldest expectation
  always @(posedge clk) begin
    meter_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: freq_now_q8 %0d", freq_now_q8);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (freq_now_q8 !== want.freq_now) begin
          $error("freq_now_q8 expected %0d actual %0d", want.freq_now, freq_now_q8);
          fail_count++;
        end
        if (freq_mean_cal_q8 !== want.freq_mean_cal) begin
          $error("freq_mean_cal_q8 expected %0d actual %0d",
                 $signed(want.freq_mean_cal), $signed(freq_mean_cal_q8));
          fail_count++;
        end
        if (capacitance_q4 !== want.cap) begin
          $error("capacitance_q4 expected %0d actual %0d", want.cap, capacitance_q4);
          fail_count++;
        end
        if (cap_clamped !== want.clamped) begin
          $error("cap_clamped expected %0d actual %0d", want.clamped, cap_clamped);
          fail_count++;
        end
      end
    end
  end

  // result side back-pressure: random stall per transfer unless idling is off
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // one timestamp transfer; valid stays up across back-to-back edges
  task automatic send_edge(logic [TS_W-1:0] ts, bit fnow_known = 0,
                           logic [FREQ_W-1:0] fnow = '0);
    int gap;
    meter_result_t r;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    edge_timestamp <= ts;
    do @(posedge clk); while (!in_ready);
    if (meter_edge(ts, r)) begin
      if (fnow_known) r.freq_now = fnow;
      pending_results.push_back(r);
    end
  endtask

  // drop valid, let the meter drain, then leave it quiet before register writes
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    model_config(idx, val);
  endtask

  // picks a calibration set; the first few phases walk the extremes
  task automatic set_calibration(int phase);
    logic [31:0] v [6];
    v[0] = $urandom_range(1000000, 200000000);
    v[1] = $urandom_range(49152, 81920);
    v[2] = $urandom_range(0, 512) - 256;
    v[3] = $urandom_range(100000, 5000000);
    v[4] = $urandom_range(0, 2048) - 1024;
    v[5] = $urandom_range(49152, 81920);
    case (phase)
      1: begin v[0] = 32'hFFFF_FFFF; v[1] = 32'h1FFFF; v[5] = 32'h1FFFF; end
      2: begin v[0] = 32'd0; v[2] = 32'hFFFF_8000; end              // zero clock
      3: begin v[1] = 32'd0; v[2] = 32'h7FFF; v[3] = 32'hFFFF_FFFF; end
      4: begin v[3] = 32'd1; v[4] = 32'hFFFF_0000; v[5] = 32'd0; end // negative c
      5: begin v[3] = 32'hFFFF_FFFF; v[4] = 32'hFFFF; v[5] = 32'h1FFFF; end
      6: begin v[1] = $urandom(); v[2] = $urandom(); v[4] = $urandom();
               v[5] = $urandom(); end                               // high bits dropped
      default: begin
        if ($urandom_range(0, 3) == 0) v[2] = $urandom();
        if ($urandom_range(0, 3) == 0) v[4] = $urandom();
        if ($urandom_range(0, 5) == 0) v[0] = $urandom();
        if ($urandom_range(0, 5) == 0) v[3] = $urandom();
      end
    endcase
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_CORE_CLOCK, v[0]);
    write_reg(REG_FREQ_GAIN, v[1]);
    write_reg(REG_FREQ_OFFSET, v[2]);
    write_reg(REG_CAP_NUM, v[3]);
    write_reg(REG_CAP_OFFSET, v[4]);
    write_reg(REG_CAP_GAIN, v[5]);
    write_reg(REG_SPARE_HI, $urandom());
    cfg_write_en <= 1'b0;
  endtask

  edge_row_t edge_rows [] = '{
    '{32'h0000_0000, 1'b0, 40'd0},           // arms only
    '{32'h0000_0000, 1'b1, 40'd18432000000}, // zero period counts as one tick
    '{32'h0000_0001, 1'b1, 40'd18432000000},
    '{32'hFFFF_FFF0, 1'b1, 40'd4},           // near-full period
    '{32'h0000_0010, 1'b1, 40'd576000000},   // counter wrap
    '{32'h0000_0010, 1'b1, 40'd18432000000},
    '{32'h0000_000F, 1'b1, 40'd4},           // largest period
    '{32'h0001_194F, 1'b1, 40'd256000},      // 1 kHz at the reset clock
    '{32'h0002_328F, 1'b1, 40'd256000},
    '{32'h0003_4BCF, 1'b1, 40'd256000},
    '{32'hAAAA_AAAA, 1'b0, 40'd0},
    '{32'h5555_5555, 1'b0, 40'd0},
    '{32'h5556_6E95, 1'b1, 40'd256000}
  };

  initial begin
    int period, jitter, pick;
    model_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed edges under reset calibration
    foreach (edge_rows[i])
      send_edge(edge_rows[i].ts, edge_rows[i].fnow_known, edge_rows[i].fnow);
    ts_now = edge_rows[edge_rows.size() - 1].ts;

    for (int phase = 1; phase <= NUM_PHASES; phase++) begin
      drain();
      set_calibration(phase);
      @(posedge clk);
      no_idle = (phase % 5 == 0);
      // oscillator period for this phase, with a little jitter per edge
      period = (phase % 3 == 0) ? $urandom_range(1, 64) : $urandom_range(500, 400000);
      jitter = period / 50 + 1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4)       ts_now = ts_now;                       // zero period
        else if (pick < 8)  ts_now = $urandom();                   // noise edge
        else if (pick < 12) ts_now = ts_now + $urandom_range(1, 16);
        else ts_now = ts_now + period + $urandom_range(0, 2 * jitter) - jitter;
        send_edge(ts_now);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
